### rtl/ppit_pkg.sv
// Shared types and codes for the polygon point-inside test block.
`timescale 1ns / 1ps

package ppit_pkg;

   localparam int COORD_FIELD_BITS = 24;
   localparam int INDEX_BITS       = 8;
   localparam int COUNT_BITS       = 9;
   localparam int OP_BITS          = 2;
   localparam int STATUS_BITS      = 2;

   localparam logic [OP_BITS-1:0] OP_APPEND = 2'd0;
   localparam logic [OP_BITS-1:0] OP_DELETE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_TEST   = 2'd2;

   localparam logic [STATUS_BITS-1:0] STATUS_OK        = 2'd0;
   localparam logic [STATUS_BITS-1:0] STATUS_FULL      = 2'd1;
   localparam logic [STATUS_BITS-1:0] STATUS_BAD_INDEX = 2'd2;

   typedef struct packed {
      logic [OP_BITS-1:0]                 op;
      logic signed [COORD_FIELD_BITS-1:0] coord_x;
      logic signed [COORD_FIELD_BITS-1:0] coord_y;
      logic [INDEX_BITS-1:0]              vertex_index;
   } req_type;

   typedef struct packed {
      logic                   inside_res;
      logic [COUNT_BITS-1:0]  count_now;
      logic [STATUS_BITS-1:0] status;
   } rsp_type;

endpackage

### rtl/ppit_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
`timescale 1ns / 1ps

module ppit_ram #(
   parameter int WIDTH = 48,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### rtl/ppit_edge.sv
// Three-stage edge crossing pipeline with crossing parity accumulator.
`timescale 1ns / 1ps

module ppit_edge #(
   parameter int COORD_BITS = 24
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         clear,
   input  logic                         edge_vld,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   input  logic [2*COORD_BITS-1:0]      vtx_a,
   input  logic [2*COORD_BITS-1:0]      vtx_b,
   output logic                         busy,
   output logic                         parity
);

   localparam int CB = COORD_BITS;
   localparam int DW = COORD_BITS + 1;
   localparam int PW = 2 * DW;

   logic signed [CB-1:0] x1, y1, x2, y2;
   logic signed [DW-1:0] pxe, pye, x1e, y1e, x2e, y2e;
   logic signed [DW-1:0] a_in, dy_in, c_in, dx_in;
   logic                 en_in;

   logic                 s1_vld_ff, en1_ff, vert1_ff, dypos1_ff;
   logic signed [DW-1:0] a_ff, dy_ff, c_ff, dx_ff;

   logic                 s2_vld_ff, en2_ff, vert2_ff, dypos2_ff;
   logic signed [PW-1:0] p1_in, p2_in, p1_ff, p2_ff;

   logic                 crossed;
   logic                 parity_ff, parity_in;

   assign x1 = vtx_a[2*CB-1:CB];
   assign y1 = vtx_a[CB-1:0];
   assign x2 = vtx_b[2*CB-1:CB];
   assign y2 = vtx_b[CB-1:0];

   assign pxe = {px[CB-1], px};
   assign pye = {py[CB-1], py};
   assign x1e = {x1[CB-1], x1};
   assign y1e = {y1[CB-1], y1};
   assign x2e = {x2[CB-1], x2};
   assign y2e = {y2[CB-1], y2};

   assign a_in  = pxe - x1e;
   assign dy_in = y2e - y1e;
   assign c_in  = pye - y1e;
   assign dx_in = x2e - x1e;
   assign en_in = (((y1 < py) && (py <= y2)) || ((y2 < py) && (py <= y1)))
                  && ((px <= x1) || (px <= x2));

   assign p1_in = PW'(a_ff) * PW'(dy_ff);
   assign p2_in = PW'(c_ff) * PW'(dx_ff);

   assign crossed = en2_ff &&
                    (vert2_ff || (dypos2_ff ? (p1_ff <= p2_ff) : (p1_ff >= p2_ff)));

   always_comb begin
      parity_in = parity_ff;
      if (clear) begin
         parity_in = 1'b0;
      end else if (s2_vld_ff && crossed) begin
         parity_in = ~parity_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         parity_ff <= 1'b0;
      end else begin
         s1_vld_ff <= edge_vld;
         s2_vld_ff <= s1_vld_ff;
         parity_ff <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      en1_ff    <= en_in;
      vert1_ff  <= (x1 == x2);
      dypos1_ff <= (y2 > y1);
      a_ff      <= a_in;
      dy_ff     <= dy_in;
      c_ff      <= c_in;
      dx_ff     <= dx_in;
      en2_ff    <= en1_ff;
      vert2_ff  <= vert1_ff;
      dypos2_ff <= dypos1_ff;
      p1_ff     <= p1_in;
      p2_ff     <= p2_in;
   end

   assign busy   = s1_vld_ff || s2_vld_ff;
   assign parity = parity_ff;

endmodule

### rtl/polygon_point_inside_test_top.sv
// Append, bad delete or unused op: the result passes through ST_FINISH into the output register.
// Delete at index i: every vertex above i moves down one place; one vertex moves per cycle.
// Test over n vertices: one edge per cycle through a 3-stage pipeline.
// One request in work at a time; the next is taken once its result is in the output register.
// Throughput is set by the single vertex RAM read port, one vertex per cycle.
// Reset clears the vertex count; RAM contents stay undefined and are never read unwritten.
`timescale 1ns / 1ps

module polygon_point_inside_test_top #(
   parameter int MAX_VERTICES = 256,
   parameter int COORD_BITS   = 24
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  ppit_pkg::req_type req_data,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output ppit_pkg::rsp_type rsp_data
);

   localparam int CB   = COORD_BITS;
   localparam int VW   = 2 * COORD_BITS;
   localparam int CW   = $clog2(MAX_VERTICES + 1);
   localparam int AW   = $clog2(MAX_VERTICES);
   localparam int CMPW = (CW > ppit_pkg::INDEX_BITS) ? CW : ppit_pkg::INDEX_BITS;
   localparam int EXTW = ppit_pkg::COORD_FIELD_BITS + 32;
   localparam int NW   = CW + ppit_pkg::COUNT_BITS;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_DELETE = 4'b0010,
      ST_TEST   = 4'b0100,
      ST_FINISH = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   logic [CW-1:0]                    count_ff, count_in;
   logic [CW-1:0]                    rd_ptr_ff, rd_ptr_in;
   logic                             rd_vld_ff, rd_vld_in;
   logic                             rd_first_ff, rd_first_in;
   logic                             rd_last_ff, rd_last_in;
   logic                             wrap_ff, wrap_in;
   logic [AW-1:0]                    wr_addr_ff, wr_addr_in;
   logic [ppit_pkg::OP_BITS-1:0]     op_ff, op_in;
   logic [ppit_pkg::STATUS_BITS-1:0] status_ff, status_in;
   logic signed [CB-1:0]             px_ff, px_in, py_ff, py_in;
   logic [VW-1:0]                    v0_ff, prev_ff;
   ppit_pkg::rsp_type                rsp_ff, rsp_in;
   logic                             rsp_valid_ff, rsp_valid_in;

   logic                             accept;
   logic                             issue;
   logic                             rsp_load;
   logic [EXTW-1:0]                  ext_x, ext_y;
   logic signed [CB-1:0]             new_x, new_y;
   logic [CMPW-1:0]                  idx_cmp, cnt_cmp;
   logic [NW-1:0]                    cnt_ext;

   logic                             ram_we, ram_re;
   logic [AW-1:0]                    ram_waddr;
   logic [VW-1:0]                    ram_wdata, ram_rdata;

   logic                             edge_clear, edge_vld, edge_busy, edge_parity;
   logic [VW-1:0]                    edge_b;

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign issue     = (rd_ptr_ff < count_ff);

   assign ext_x   = EXTW'(unsigned'(req_data.coord_x));
   assign ext_y   = EXTW'(unsigned'(req_data.coord_y));
   assign new_x   = ext_x[CB-1:0];
   assign new_y   = ext_y[CB-1:0];
   assign idx_cmp = CMPW'(req_data.vertex_index);
   assign cnt_cmp = CMPW'(count_ff);
   assign cnt_ext = NW'(count_ff);

   always_comb begin
      state_in    = state_ff;
      count_in    = count_ff;
      rd_ptr_in   = rd_ptr_ff;
      rd_vld_in   = 1'b0;
      rd_first_in = rd_first_ff;
      rd_last_in  = rd_last_ff;
      wrap_in     = 1'b0;
      wr_addr_in  = wr_addr_ff;
      op_in       = op_ff;
      status_in   = status_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      ram_we      = 1'b0;
      ram_waddr   = count_ff[AW-1:0];
      ram_wdata   = {new_x, new_y};
      ram_re      = 1'b0;
      edge_clear  = 1'b0;
      rsp_load    = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in      = req_data.op;
               px_in      = new_x;
               py_in      = new_y;
               status_in  = ppit_pkg::STATUS_OK;
               rd_ptr_in  = '0;
               edge_clear = 1'b1;
               state_in   = ST_FINISH;
               unique case (req_data.op)
                  ppit_pkg::OP_APPEND: begin
                     if (count_ff >= CW'(MAX_VERTICES)) begin
                        status_in = ppit_pkg::STATUS_FULL;
                     end else begin
                        ram_we   = 1'b1;
                        count_in = CW'(count_ff + 1'b1);
                     end
                  end
                  ppit_pkg::OP_DELETE: begin
                     if (idx_cmp >= cnt_cmp) begin
                        status_in = ppit_pkg::STATUS_BAD_INDEX;
                     end else begin
                        rd_ptr_in = CW'(idx_cmp + 1'b1);
                        state_in  = ST_DELETE;
                     end
                  end
                  ppit_pkg::OP_TEST: begin
                     state_in = ST_TEST;
                  end
                  default: begin
                     state_in = ST_FINISH;
                  end
               endcase
            end
         end
         ST_DELETE: begin
            if (issue) begin
               ram_re     = 1'b1;
               rd_ptr_in  = CW'(rd_ptr_ff + 1'b1);
               rd_vld_in  = 1'b1;
               wr_addr_in = AW'(rd_ptr_ff - 1'b1);
            end
            if (rd_vld_ff) begin
               ram_we    = 1'b1;
               ram_waddr = wr_addr_ff;
               ram_wdata = ram_rdata;
            end
            if (!issue && !rd_vld_ff) begin
               count_in = CW'(count_ff - 1'b1);
               state_in = ST_FINISH;
            end
         end
         ST_TEST: begin
            if (issue) begin
               ram_re      = 1'b1;
               rd_ptr_in   = CW'(rd_ptr_ff + 1'b1);
               rd_vld_in   = 1'b1;
               rd_first_in = (rd_ptr_ff == '0);
               rd_last_in  = (CW'(rd_ptr_ff + 1'b1) == count_ff);
            end
            wrap_in = rd_vld_ff && rd_last_ff;
            if (!issue && !rd_vld_ff && !wrap_ff && !edge_busy) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_in            = rsp_ff;
      rsp_valid_in      = rsp_valid_ff;
      if (rsp_load) begin
         rsp_in.inside_res = (op_ff == ppit_pkg::OP_TEST) ? edge_parity : 1'b0;
         rsp_in.count_now  = cnt_ext[ppit_pkg::COUNT_BITS-1:0];
         rsp_in.status     = status_ff;
         rsp_valid_in      = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   assign edge_vld = (state_ff == ST_TEST) && ((rd_vld_ff && !rd_first_ff) || wrap_ff);
   assign edge_b   = wrap_ff ? v0_ff : ram_rdata;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rd_vld_ff    <= 1'b0;
         wrap_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_vld_ff    <= rd_vld_in;
         wrap_ff      <= wrap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff   <= rd_ptr_in;
      rd_first_ff <= rd_first_in;
      rd_last_ff  <= rd_last_in;
      wr_addr_ff  <= wr_addr_in;
      op_ff       <= op_in;
      status_ff   <= status_in;
      px_ff       <= px_in;
      py_ff       <= py_in;
      rsp_ff      <= rsp_in;
      if (rd_vld_ff) begin
         prev_ff <= ram_rdata;
         if (rd_first_ff) begin
            v0_ff <= ram_rdata;
         end
      end
   end

   ppit_ram #(
      .WIDTH (VW),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (rd_ptr_ff[AW-1:0]),
      .rd_data (ram_rdata)
   );

   ppit_edge #(
      .COORD_BITS (COORD_BITS)
   ) u_edge (
      .clock    (clock),
      .reset    (reset),
      .clear    (edge_clear),
      .edge_vld (edge_vld),
      .px       (px_ff),
      .py       (py_ff),
      .vtx_a    (prev_ff),
      .vtx_b    (edge_b),
      .busy     (edge_busy),
      .parity   (edge_parity)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule
